[hw/rtl/erd_pkg.sv]
// ----------------------------------------------------------------------------
// erd_pkg
// Shared widths, controller states, datapath step codes, the command and
// status structs and the month lengths of the Easter relative date block.
// ----------------------------------------------------------------------------
package erd_pkg;

   localparam int YEAR_W  = 14;
   localparam int OFF_W   = 7;
   localparam int DAY_W   = 5;
   localparam int MONTH_W = 4;
   localparam int DOY_W   = 9;

   // month index of december, the walk never steps past it
   localparam logic [MONTH_W-1:0] LAST_MONTH_IDX = MONTH_W'(11);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIV,
      ST_FIX,
      ST_FQ,
      ST_GQ,
      ST_HQ,
      ST_LQ,
      ST_MV,
      ST_DOY,
      ST_WALK,
      ST_OUT
   } ctl_state_type;

   typedef enum logic [3:0] {
      STEP_NONE,
      STEP_DIV,
      STEP_FIX,
      STEP_FQ,
      STEP_GQ,
      STEP_HQ,
      STEP_LQ,
      STEP_MV,
      STEP_DOY,
      STEP_WALK
   } dp_step_type;

   typedef struct packed {
      logic        load;
      dp_step_type step;
      logic        load_out;
   } dp_cmd_type;

   typedef struct packed {
      logic walk_done;
   } dp_status_type;

   function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] idx,
                                                  input logic leap);
      logic [DAY_W-1:0] n;
      case (idx)
         MONTH_W'(1): n = leap ? DAY_W'(29) : DAY_W'(28);
         MONTH_W'(3), MONTH_W'(5), MONTH_W'(8), MONTH_W'(10): n = DAY_W'(30);
         default: n = DAY_W'(31);
      endcase
      return n;
   endfunction

endpackage

[hw/rtl/easter_relative_date.sv]
// ----------------------------------------------------------------------------
// easter_relative_date
// Finds Easter Sunday of a Gregorian year and shifts it by a signed number
// of days, giving day of month and month.
//
//   channel | ports                               | direction
//   --------+-------------------------------------+----------
//   request | req_valid req_stall req_year        | in
//           | req_day_offset                      |
//   result  | rsp_valid rsp_stall                 | out
//           | rsp_day_of_month rsp_month_number   |
//
// one transaction at a time: a new request is taken only once the last result
// is loaded; eight computus steps, a walk that steps one month at a time until
// the date falls in the current month, one result load and the idle accept
// a finished result waits in the output register while a new request is
// taken; a stalled older result holds the next load until it is taken
// reset is synchronous and clears the sequencer and the result valid only
// ----------------------------------------------------------------------------
module easter_relative_date import erd_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [YEAR_W-1:0]       req_year,
   input  logic signed [OFF_W-1:0] req_day_offset,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [DAY_W-1:0]        rsp_day_of_month,
   output logic [MONTH_W-1:0]      rsp_month_number
);

   dp_cmd_type    cmd;
   dp_status_type status;

   erd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status)
   );

   erd_dpath u_dpath (
      .clock            (clock),
      .cmd              (cmd),
      .status           (status),
      .req_year         (req_year),
      .req_day_offset   (req_day_offset),
      .rsp_day_of_month (rsp_day_of_month),
      .rsp_month_number (rsp_month_number)
   );

endmodule

[hw/rtl/erd_ctrl.sv]
// ----------------------------------------------------------------------------
// erd_ctrl
// Sequencer: walks the datapath through the computus steps and the month
// walk, and owns both handshakes.
// ----------------------------------------------------------------------------
module erd_ctrl import erd_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output dp_cmd_type    cmd,
   input  dp_status_type status
);

   ctl_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (req_valid) state_in = ST_DIV;
         ST_DIV:  state_in = ST_FIX;
         ST_FIX:  state_in = ST_FQ;
         ST_FQ:   state_in = ST_GQ;
         ST_GQ:   state_in = ST_HQ;
         ST_HQ:   state_in = ST_LQ;
         ST_LQ:   state_in = ST_MV;
         ST_MV:   state_in = ST_DOY;
         ST_DOY:  state_in = ST_WALK;
         ST_WALK: if (status.walk_done) state_in = ST_OUT;
         ST_OUT:  if (out_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd.load     = 1'b0;
      cmd.step     = STEP_NONE;
      cmd.load_out = 1'b0;
      req_stall    = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            cmd.load  = req_valid;
         end
         ST_DIV:  cmd.step = STEP_DIV;
         ST_FIX:  cmd.step = STEP_FIX;
         ST_FQ:   cmd.step = STEP_FQ;
         ST_GQ:   cmd.step = STEP_GQ;
         ST_HQ:   cmd.step = STEP_HQ;
         ST_LQ:   cmd.step = STEP_LQ;
         ST_MV:   cmd.step = STEP_MV;
         ST_DOY:  cmd.step = STEP_DOY;
         ST_WALK: cmd.step = STEP_WALK;
         ST_OUT:  cmd.load_out = out_free;
         default: cmd.step = STEP_NONE;
      endcase
   end

   always_comb begin
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

[hw/rtl/erd_dpath.sv]
// ----------------------------------------------------------------------------
// erd_dpath
// Computus datapath: constant divisions by reciprocal multiply with one
// correction, Easter day of year, offset add and a month-by-month walk.
// ----------------------------------------------------------------------------
module erd_dpath import erd_pkg::*; (
   input  logic                 clock,
   input  dp_cmd_type           cmd,
   output dp_status_type        status,
   input  logic [YEAR_W-1:0]    req_year,
   input  logic signed [OFF_W-1:0] req_day_offset,
   output logic [DAY_W-1:0]     rsp_day_of_month,
   output logic [MONTH_W-1:0]   rsp_month_number
);

   // floor reciprocals, quotient is low by at most one
   localparam int RECIP100 = 5242;   // 2^19 / 100
   localparam int RECIP19  = 55188;  // 2^20 / 19
   localparam int RECIP25  = 40;     // 2^10 / 25
   localparam int RECIP3   = 341;    // 2^10 / 3
   localparam int RECIP30  = 34;     // 2^10 / 30
   localparam int RECIP7   = 36;     // 2^8 / 7

   logic [YEAR_W-1:0]        year_ff, year_in;
   logic signed [OFF_W-1:0]  off_ff, off_in;
   logic [7:0]               q100_ff, q100_in;
   logic [9:0]               q19_ff, q19_in;
   logic [7:0]               b_ff, b_in;
   logic [6:0]               c_ff, c_in;
   logic [4:0]               a_ff, a_in;
   logic                     leap_ff, leap_in;
   logic [2:0]               f_ff, f_in;
   logic [5:0]               g_ff, g_in;
   logic [4:0]               h_ff, h_in;
   logic [2:0]               l_ff, l_in;
   logic [7:0]               v_ff, v_in;
   logic [DOY_W-1:0]         doy_ff, doy_in;
   logic [MONTH_W-1:0]       mon_ff, mon_in;
   logic [DAY_W-1:0]         day_out_ff, day_out_in;
   logic [MONTH_W-1:0]       mon_out_ff, mon_out_in;

   logic [26:0] p100;
   logic [29:0] p19;
   logic [14:0] r100, r19;
   logic [7:0]  fx, fr, gx, gr;
   logic [13:0] fp;
   logic [15:0] gp;
   logic [9:0]  hx, hr, mx;
   logic [15:0] hp;
   logic [6:0]  lx, lr;
   logic [12:0] lp;
   logic [DAY_W-1:0] len;
   logic        step_on;

   assign p100 = 27'(year_ff) * 27'(RECIP100);
   assign p19  = 30'(year_ff) * 30'(RECIP19);
   assign r100 = 15'(year_ff) - 15'(q100_ff) * 15'(100);
   assign r19  = 15'(year_ff) - 15'(q19_ff) * 15'(19);

   assign fx = b_ff + 8'd8;
   assign fp = 14'(fx) * 14'(RECIP25);
   assign fr = fx - 8'(fp[13:10]) * 8'd25;

   assign gx = b_ff - 8'(f_ff) + 8'd1;
   assign gp = 16'(gx) * 16'(RECIP3);
   assign gr = gx - 8'(gp[15:10]) * 8'd3;

   assign hx = 10'(a_ff) * 10'd19 + 10'(b_ff) - 10'(b_ff[7:2]) - 10'(g_ff) + 10'd15;
   assign hp = 16'(hx) * 16'(RECIP30);
   assign hr = hx - 10'(hp[14:10]) * 10'd30;

   assign lx = 7'd32 + 7'({b_ff[1:0], 1'b0}) + 7'({c_ff[6:2], 1'b0})
             - 7'(h_ff) - 7'(c_ff[1:0]);
   assign lp = 13'(lx) * 13'(RECIP7);
   assign lr = lx - 7'(lp[11:8]) * 7'd7;

   assign mx = 10'(a_ff) + 10'(h_ff) * 10'd11 + 10'(l_ff) * 10'd22;

   assign len     = month_days(mon_ff, leap_ff);
   assign step_on = (mon_ff < LAST_MONTH_IDX) && (doy_ff > DOY_W'(len));
   assign status.walk_done = !step_on;

   always_comb begin
      year_in    = year_ff;
      off_in     = off_ff;
      q100_in    = q100_ff;
      q19_in     = q19_ff;
      b_in       = b_ff;
      c_in       = c_ff;
      a_in       = a_ff;
      leap_in    = leap_ff;
      f_in       = f_ff;
      g_in       = g_ff;
      h_in       = h_ff;
      l_in       = l_ff;
      v_in       = v_ff;
      doy_in     = doy_ff;
      mon_in     = mon_ff;
      day_out_in = day_out_ff;
      mon_out_in = mon_out_ff;

      if (cmd.load) begin
         year_in = req_year;
         off_in  = req_day_offset;
      end

      if (cmd.load_out) begin
         day_out_in = doy_ff[DAY_W-1:0];
         mon_out_in = mon_ff + MONTH_W'(1);
      end

      case (cmd.step)
         STEP_DIV: begin
            q100_in = p100[26:19];
            q19_in  = p19[29:20];
         end
         STEP_FIX: begin
            if (r100 >= 15'd100) begin
               b_in = q100_ff + 8'd1;
               c_in = 7'(r100 - 15'd100);
            end else begin
               b_in = q100_ff;
               c_in = 7'(r100);
            end
            a_in = (r19 >= 15'd19) ? 5'(r19 - 15'd19) : 5'(r19);
         end
         STEP_FQ: begin
            // divisible by 4, and not a century unless divisible by 400
            leap_in = (c_ff[1:0] == 2'd0) && ((c_ff != 7'd0) || (b_ff[1:0] == 2'd0));
            f_in    = (fr >= 8'd25) ? 3'(fp[13:10] + 4'd1) : 3'(fp[13:10]);
         end
         STEP_GQ: begin
            g_in = (gr >= 8'd3) ? 6'(gp[15:10] + 6'd1) : gp[15:10];
         end
         STEP_HQ: begin
            h_in = (hr >= 10'd30) ? 5'(hr - 10'd30) : 5'(hr);
         end
         STEP_LQ: begin
            l_in = (lr >= 7'd7) ? 3'(lr - 7'd7) : 3'(lr);
         end
         STEP_MV: begin
            v_in = 8'(h_ff) + 8'(l_ff) + 8'd114 - ((mx >= 10'd451) ? 8'd7 : 8'd0);
         end
         STEP_DOY: begin
            // march or april alike: day of year of easter is v - 33 + leap
            doy_in = DOY_W'(v_ff) - DOY_W'(33) + DOY_W'(leap_ff)
                   + {{(DOY_W-OFF_W){off_ff[OFF_W-1]}}, off_ff};
            mon_in = '0;
         end
         STEP_WALK: begin
            if (step_on) begin
               doy_in = doy_ff - DOY_W'(len);
               mon_in = mon_ff + MONTH_W'(1);
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      year_ff    <= year_in;
      off_ff     <= off_in;
      q100_ff    <= q100_in;
      q19_ff     <= q19_in;
      b_ff       <= b_in;
      c_ff       <= c_in;
      a_ff       <= a_in;
      leap_ff    <= leap_in;
      f_ff       <= f_in;
      g_ff       <= g_in;
      h_ff       <= h_in;
      l_ff       <= l_in;
      v_ff       <= v_in;
      doy_ff     <= doy_in;
      mon_ff     <= mon_in;
      day_out_ff <= day_out_in;
      mon_out_ff <= mon_out_in;
   end

   assign rsp_day_of_month = day_out_ff;
   assign rsp_month_number = mon_out_ff;

endmodule

[hw/rtl/erd_checker.sv]
// ----------------------------------------------------------------------------
// erd_checker
// Port-level checks for the Easter relative date block, bound to the top.
// ----------------------------------------------------------------------------
module erd_checker import erd_pkg::*; (
   input logic                    clock,
   input logic                    reset,
   input logic                    req_valid,
   input logic                    req_stall,
   input logic                    rsp_valid,
   input logic                    rsp_stall,
   input logic [DAY_W-1:0]        rsp_day_of_month,
   input logic [MONTH_W-1:0]      rsp_month_number
);

   logic req_take;
   assign req_take = req_valid && !req_stall;

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_day_of_month)
                                 && $stable(rsp_month_number))
      else $error("stalled result changed");

   a_rsp_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_month_number >= MONTH_W'(1) && rsp_month_number <= MONTH_W'(6)
                    && rsp_day_of_month != DAY_W'(0))
      else $error("result date out of range");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_take |=> req_stall)
      else $error("second request taken while busy");

   a_no_early_rsp: assert property (@(posedge clock) disable iff (reset)
      req_take && !rsp_valid |=> !rsp_valid)
      else $error("result appeared right after accept");

endmodule

bind easter_relative_date erd_checker u_erd_checker (.*);
